@@ design/psfp_pkg.sv @@
// package for the particle sensor frame parser
// frame geometry constants and the structs passed between the submodules
// no dependencies
package psfp_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int DATA_WORDS  = 13;
  localparam int FIT_WORDS   = (FRAME_BYTES - 4) / 2;
  localparam int EMIT_WORDS  = (DATA_WORDS < FIT_WORDS) ? DATA_WORDS : FIT_WORDS;
  localparam int POS_W       = 6;
  localparam int ADDR_W      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int SUM_END     = FRAME_BYTES - 2;
  localparam int WORD_END    = 2 + 2 * EMIT_WORDS;
  localparam int INDEX_W     = 4;

  localparam logic [7:0] START_RESET = 8'h42;

  // word store write request from the frame parser
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } wr_req_t;

  // run start request issued on the final frame byte
  typedef struct packed {
    logic valid;
    logic ok;
    logic bank;
  } run_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [15:0]        value;
    logic               ok;
    logic               last;
  } result_t;

endpackage

@@ design/psfp_if.sv @@
// valid/ready channel interfaces of the particle sensor frame parser
// configuration, received byte and result word channels; no dependencies
interface psfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_byte;

  modport source (output valid, output start_byte, input ready);
  modport sink (input valid, input start_byte, output ready);
endinterface

interface psfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface psfp_word_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        checksum_ok;
  logic        last;

  modport source (output valid, output word_index, output word_value,
                  output checksum_ok, output last, input ready);
  modport sink (input valid, input word_index, input word_value,
                input checksum_ok, input last, output ready);
endinterface

@@ design/psfp_word_ram.sv @@
// two-bank word store, one write port and one registered read port
// depends on psfp_pkg
module psfp_word_ram import psfp_pkg::*; (
  input  logic              clk_i,
  input  wr_req_t           wr_i,
  input  logic              rd_en_i,
  input  logic              rd_bank_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem_q [2][DATA_WORDS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_bank_i][rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/psfp_frame_ctrl.sv @@
// frame hunter and byte parser: position counter, running sum, word packing
// depends on psfp_pkg and psfp_if
module psfp_frame_ctrl import psfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  psfp_cfg_if.sink   cfg_i,
  psfp_byte_if.sink  rx_i,
  input  logic       emit_busy_i,
  output wr_req_t    wr_o,
  output run_req_t   run_o
);

  localparam logic [POS_W-1:0] FrameLast = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SumEnd    = POS_W'(SUM_END);
  localparam logic [POS_W-1:0] WordEnd   = POS_W'(WORD_END);

  logic [7:0]       start_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic             bank_q, bank_d;
  logic [7:0]       hold_q;
  logic [7:0]       chk_hi_q;
  logic             is_last;
  logic             acc;
  logic [7:0]       b;
  logic [POS_W-1:0] half_pos;

  assign b       = rx_i.rx_byte;
  assign is_last = (pos_q == FrameLast);
  // final byte waits until the previous run has issued its last word store read
  assign rx_i.ready  = !(is_last && emit_busy_i);
  assign acc         = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;
  assign half_pos    = pos_q >> 1;

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    if (acc) begin
      if (pos_q == '0) begin
        if (b == start_q) begin
          sum_d = {8'h00, b};
          pos_d = POS_W'(1);
        end
      end else begin
        if (pos_q < SumEnd) begin
          sum_d = sum_q + {8'h00, b};
        end
        if (is_last) begin
          pos_d  = '0;
          bank_d = !bank_q;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    wr_o.en   = acc && (pos_q >= POS_W'(2)) && (pos_q < WordEnd) && pos_q[0];
    wr_o.bank = bank_q;
    wr_o.addr = ADDR_W'(half_pos - POS_W'(1));
    wr_o.data = {hold_q, b};
    run_o.valid = acc && is_last;
    run_o.ok    = (sum_q == {chk_hi_q, b});
    run_o.bank  = bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      pos_q   <= '0;
      sum_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        start_q <= cfg_i.start_byte;
      end
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (pos_q >= POS_W'(2)) && (pos_q < WordEnd) && !pos_q[0]) begin
      hold_q <= b;
    end
    if (acc && (pos_q == SumEnd)) begin
      chk_hi_q <= b;
    end
  end

endmodule

@@ design/psfp_emit.sv @@
// result run sequencer: reads the word store and feeds a two-entry output queue
// depends on psfp_pkg and psfp_if
module psfp_emit import psfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  run_req_t          run_i,
  output logic              busy_o,
  output logic              rd_en_o,
  output logic              rd_bank_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [15:0]       rdata_i,
  psfp_word_if.source       res_o
);

  localparam logic [ADDR_W-1:0] LastIdx = ADDR_W'(EMIT_WORDS - 1);

  logic              active_q;
  logic              ok_q;
  logic              bank_q;
  logic [ADDR_W-1:0] idx_q;

  logic              pend_q;
  logic [ADDR_W-1:0] pend_idx_q;
  logic              pend_ok_q;
  logic              pend_last_q;

  result_t           ent_q [2];
  result_t           head;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic [1:0]        occ;
  logic              pop;
  logic              issue;
  logic              run_last;

  assign head        = ent_q[rd_ptr_q];
  assign res_o.valid = (cnt_q != 2'd0);
  assign res_o.word_index  = head.index;
  assign res_o.word_value  = head.value;
  assign res_o.checksum_ok = head.ok;
  assign res_o.last        = head.last;
  assign pop         = res_o.valid && res_o.ready;

  // queue entries plus the read in flight must not exceed the queue depth
  assign occ      = cnt_q + {1'b0, pend_q};
  assign issue    = active_q && ((occ < 2'd2) || pop);
  assign run_last = !ok_q || (idx_q == LastIdx);

  assign busy_o    = active_q;
  assign rd_en_o   = issue;
  assign rd_bank_o = bank_q;
  assign rd_addr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ok_q     <= 1'b0;
      bank_q   <= 1'b0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (run_i.valid) begin
        active_q <= 1'b1;
        ok_q     <= run_i.ok;
        bank_q   <= run_i.bank;
        idx_q    <= '0;
      end else if (issue) begin
        if (run_last) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + ADDR_W'(1);
      end
      pend_q <= issue;
      if (pend_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, pend_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_idx_q  <= idx_q;
      pend_ok_q   <= ok_q;
      pend_last_q <= run_last;
    end
    if (pend_q) begin
      ent_q[wr_ptr_q].index <= INDEX_W'(pend_idx_q);
      ent_q[wr_ptr_q].value <= pend_ok_q ? rdata_i : 16'h0000;
      ent_q[wr_ptr_q].ok    <= pend_ok_q;
      ent_q[wr_ptr_q].last  <= pend_last_q;
    end
  end

endmodule

@@ design/particle_sensor_frame_parser.sv @@
// particle sensor frame parser: one byte per cycle, 13-word result run per good frame
// first result goes through the emit run state, the word store read and the queue
// throughput: one byte per cycle; results stream one per cycle while res_o is ready
// a frame's final byte stalls while the previous run still issues word store reads
// reset: async active low, hunting for start byte 0x42; word store is not cleared
// depends on psfp_pkg, psfp_if, psfp_frame_ctrl, psfp_word_ram, psfp_emit
module particle_sensor_frame_parser import psfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  psfp_cfg_if.sink    cfg_i,
  psfp_byte_if.sink   rx_i,
  psfp_word_if.source res_o
);

  wr_req_t           wr;
  run_req_t          run;
  logic              emit_busy;
  logic              rd_en;
  logic              rd_bank;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rdata;

  psfp_frame_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .rx_i        (rx_i),
    .emit_busy_i (emit_busy),
    .wr_o        (wr),
    .run_o       (run)
  );

  psfp_word_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_bank_i (rd_bank),
    .rd_addr_i (rd_addr),
    .rdata_o   (rdata)
  );

  psfp_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_i     (run),
    .busy_o    (emit_busy),
    .rd_en_o   (rd_en),
    .rd_bank_o (rd_bank),
    .rd_addr_o (rd_addr),
    .rdata_i   (rdata),
    .res_o     (res_o)
  );

endmodule

@@ verif/particle_sensor_frame_parser_tb.sv @@
// testbench for the particle sensor frame parser: random and directed byte frames
// a scoreboard class predicts each result run; depends on psfp_pkg and psfp_if
module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_SETTINGS  = 5;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MARK} fill_e;

  class frame_result_board;
    logic [7:0]  start_val;
    int unsigned pos;
    logic [15:0] sum;
    logic [7:0]  hold;
    logic [15:0] words [DATA_WORDS];
    logic [15:0] rx_check;
    result_t     expected_words [$];
    int          mismatch_count;

    function new();
      start_val      = START_RESET;
      pos            = 0;
      sum            = '0;
      hold           = '0;
      rx_check       = '0;
      mismatch_count = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function bit frame_open();
      return pos != 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned p;
      int unsigned w;
      result_t r;
      p = pos;
      if (p == 0) begin
        if (b == start_val) begin
          sum = 16'(b);
          pos = 1;
        end
        return;
      end
      if (p < SUM_END) sum = sum + 16'(b);
      if (p >= 2 && p < WORD_END) begin
        if (p % 2 == 0) begin
          hold = b;
        end else begin
          w = (p - 3) / 2;
          if (w < DATA_WORDS) words[w] = {hold, b};
        end
      end
      if (p == FRAME_BYTES - 2) rx_check = {b, 8'h00};
      else if (p == FRAME_BYTES - 1) rx_check[7:0] = b;
      if (p + 1 < FRAME_BYTES) begin
        pos = p + 1;
        return;
      end
      pos = 0;
      if (sum != rx_check) begin
        // checksum failure gives one error request
        r = '{index: '0, value: '0, ok: 1'b0, last: 1'b1};
        expected_words.push_back(r);
      end else begin
        for (int k = 0; k < EMIT_WORDS; k++) begin
          r.index = 4'(k);
          r.value = words[k];
          r.ok    = 1'b1;
          r.last  = (k == EMIT_WORDS - 1);
          expected_words.push_back(r);
        end
      end
    endfunction

    function void check_word(result_t got);
      result_t exp_r;
      if (expected_words.size() == 0) begin
        $error("result with nothing expected: index %0d value %0h", got.index, got.value);
        mismatch_count++;
        return;
      end
      exp_r = expected_words.pop_front();
      if (got.index !== exp_r.index) begin
        $error("word_index: expected %0d, got %0d", exp_r.index, got.index);
        mismatch_count++;
      end
      if (got.value !== exp_r.value) begin
        $error("word_value: expected %04h, got %04h", exp_r.value, got.value);
        mismatch_count++;
      end
      if (got.ok !== exp_r.ok) begin
        $error("checksum_ok: expected %0b, got %0b", exp_r.ok, got.ok);
        mismatch_count++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, got.last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idling = 1'b1;
  int   stall_left = 0;
  logic [7:0] start_list [NUM_SETTINGS];
  frame_result_board board = new();

  psfp_cfg_if  cfg_bus ();
  psfp_byte_if rx_bus ();
  psfp_word_if res_bus ();

  particle_sensor_frame_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .rx_i   (rx_bus),
    .res_o  (res_bus)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic send_byte(input logic [7:0] b);
    if (idling && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    board.note_byte(b);
  endtask

  task automatic send_stray();
    logic [7:0] v;
    v = 8'($urandom);
    // mostly keep strays from opening a frame
    if (v == board.start_val && $urandom_range(0, 3) != 0) v = ~v;
    send_byte(v);
  endtask

  task automatic send_frame(input bit good, input fill_e fill);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] total;
    int unsigned spot;
    total = '0;
    fr[0] = board.start_val;
    for (int i = 1; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZERO: fr[i] = 8'h00;
        FILL_ONES: fr[i] = 8'hFF;
        FILL_MARK: fr[i] = $urandom_range(0, 1) ? board.start_val : 8'($urandom);
        default:   fr[i] = 8'($urandom);
      endcase
    end
    for (int i = 0; i < SUM_END; i++) total = total + 16'(fr[i]);
    fr[SUM_END]     = total[15:8];
    fr[SUM_END + 1] = total[7:0];
    // one flipped bit anywhere after the start byte always breaks the sum
    if (!good) begin
      spot = $urandom_range(1, FRAME_BYTES - 1);
      fr[spot] = fr[spot] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i]);
  endtask

  task automatic settle();
    while (board.frame_open()) send_byte(8'($urandom));
    rx_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.start_byte <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    board.start_val = v;
  endtask

  task automatic run_phase(input int frames);
    fill_e fill;
    repeat (frames) begin
      repeat ($urandom_range(0, 3)) send_stray();
      // truncated frame: the next start byte lands inside it as data
      if ($urandom_range(0, 7) == 0) begin
        send_byte(board.start_val);
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
      end
      case ($urandom_range(0, 9))
        0:       fill = FILL_ZERO;
        1:       fill = FILL_ONES;
        2, 3:    fill = FILL_MARK;
        default: fill = FILL_RANDOM;
      endcase
      send_frame($urandom_range(0, 3) != 0, fill);
    end
    settle();
  endtask

  // result side: check accepted requests and stall in bursts
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        board.check_word('{index: res_bus.word_index, value: res_bus.word_value,
                           ok: res_bus.checksum_ok, last: res_bus.last});
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    rx_bus.valid       <= 1'b0;
    rx_bus.rx_byte     <= 8'h00;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.start_byte <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting drops, extreme data, bad checksum, start byte as data
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_frame(1'b1, FILL_ONES);
    send_frame(1'b0, FILL_ZERO);
    send_frame(1'b1, FILL_MARK);
    settle();

    start_list = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), START_RESET};
    for (int i = 0; i < NUM_SETTINGS; i++) begin
      if (i == NUM_SETTINGS - 1) idling = 1'b0;
      write_start(start_list[i]);
      run_phase((i % 2 == 0) ? 2 : 1);
    end

    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
